// ===== rtl/bwf_pkg.sv =====
package bwf_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned TURN_W  = 17;
	localparam int unsigned CFG_W   = 16;

	typedef enum logic [1:0] {
		CFG_TARGET_SPEED  = 2'd0,
		CFG_WIRE_REVERSED = 2'd1,
		CFG_FACING_MARGIN = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_index_t;

	localparam logic [7:0] FACING_MARGIN_RST = 8'd26;

	localparam logic [1:0] SIDE_INSIDE  = 2'd0;
	localparam logic [1:0] SIDE_OUTSIDE = 2'd1;

	localparam logic CMD_START = 1'b1;

	typedef enum logic [3:0] {
		P_MISSING    = 4'd0,
		P_IN_NORMAL  = 4'd1,
		P_IN_LHRL    = 4'd2,
		P_IN_LLRH    = 4'd3,
		P_OUT_NORMAL = 4'd4,
		P_OUT_LHRL   = 4'd5,
		P_OUT_LLRH   = 4'd6,
		P_ALIGNED    = 4'd7,
		P_REVERSE    = 4'd8
	} pose_t;

	typedef struct packed {
		logic                       command;
		logic [1:0]                 left_side;
		logic [1:0]                 right_side;
		logic signed [LEVEL_W-1:0]  left_level;
		logic signed [LEVEL_W-1:0]  right_level;
	} in_t;

	typedef struct packed {
		logic signed [TURN_W-1:0]   turn_rate;
		logic [SPEED_W-1:0]         forward_speed;
		logic                       wire_lost;
		logic [2:0]                 mode_now;
		logic [3:0]                 pose_class;
	} out_t;

endpackage

// ===== rtl/bwf_classify.sv =====
module bwf_classify
	import bwf_pkg::*;
(
	input  in_t        item,
	input  logic [7:0] facing_margin,
	input  logic       wire_reversed,
	output pose_t      pose
);

	logic [LEVEL_W:0]   mag_l;
	logic [LEVEL_W:0]   mag_r;
	logic [LEVEL_W+8:0] scaled_l;
	logic [LEVEL_W+8:0] scaled_r;
	logic [LEVEL_W+8:0] margin_l;
	logic [LEVEL_W+8:0] margin_r;
	logic [8:0]         k;
	logic               balanced;
	logic               left_in;

	always_comb begin
		mag_l = item.left_level[LEVEL_W-1] ?
			(LEVEL_W+1)'(-$signed({item.left_level[LEVEL_W-1], item.left_level})) :
			{1'b0, item.left_level};
		mag_r = item.right_level[LEVEL_W-1] ?
			(LEVEL_W+1)'(-$signed({item.right_level[LEVEL_W-1], item.right_level})) :
			{1'b0, item.right_level};
		k        = {1'b1, facing_margin};
		scaled_l = (LEVEL_W+9)'({mag_l, 8'h00});
		scaled_r = (LEVEL_W+9)'({mag_r, 8'h00});
		margin_l = (LEVEL_W+9)'(mag_l) * (LEVEL_W+9)'(k);
		margin_r = (LEVEL_W+9)'(mag_r) * (LEVEL_W+9)'(k);
		balanced = (scaled_l < margin_r) && (scaled_r < margin_l);
		left_in  = (item.left_side == SIDE_INSIDE);

		if (item.left_side[1] || item.right_side[1]) begin
			pose = P_MISSING;
		end else if (item.left_side == item.right_side) begin
			if (balanced) begin
				pose = left_in ? P_IN_NORMAL : P_OUT_NORMAL;
			end else if (mag_l > mag_r) begin
				pose = left_in ? P_IN_LHRL : P_OUT_LHRL;
			end else begin
				pose = left_in ? P_IN_LLRH : P_OUT_LLRH;
			end
		end else if (left_in != wire_reversed) begin
			pose = P_ALIGNED;
		end else begin
			pose = P_REVERSE;
		end
	end

endmodule

// ===== rtl/bwf_ctrl.sv =====
module bwf_ctrl
	import bwf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  in_t                item,
	input  pose_t              pose,
	input  logic [SPEED_W-1:0] target_speed,
	input  logic               wire_reversed,
	output out_t               result
);

	typedef enum logic [2:0] {
		M_IDLE     = 3'd0,
		M_START    = 3'd1,
		M_FINDDIR  = 3'd2,
		M_GOTOLINE = 3'd3,
		M_ALIGNING = 3'd4,
		M_TRACE    = 3'd5,
		M_DONE     = 3'd6
	} mode_t;

	mode_t mode_q;
	mode_t mode_d;
	logic  entry_q;
	logic  entry_d;

	logic [SPEED_W-1:0]       frac64;
	logic [SPEED_W-1:0]       frac192;
	logic [SPEED_W-1:0]       frac26;
	logic signed [TURN_W-1:0] tgt_s;
	logic signed [TURN_W-1:0] f64_s;
	logic signed [TURN_W-1:0] f192_s;
	logic signed [TURN_W-1:0] f26_s;
	logic signed [TURN_W-1:0] ang;
	logic [SPEED_W-1:0]       lin;
	logic                     lost;
	logic                     sl;
	logic                     sr;
	logic                     pos_dir;

	always_comb begin
		frac64  = {2'b00, target_speed[SPEED_W-1:2]};
		frac192 = SPEED_W'(((SPEED_W+2)'(target_speed) * (SPEED_W+2)'(3)) >> 2);
		frac26  = SPEED_W'(((SPEED_W+5)'(target_speed) * (SPEED_W+5)'(26)) >> 8);
		tgt_s   = $signed({1'b0, target_speed});
		f64_s   = $signed({1'b0, frac64});
		f192_s  = $signed({1'b0, frac192});
		f26_s   = $signed({1'b0, frac26});
		sl      = item.left_side[0];
		sr      = item.right_side[0];
		pos_dir = wire_reversed ? (item.left_side == SIDE_INSIDE) :
			(item.left_side == SIDE_OUTSIDE);

		mode_d  = mode_q;
		entry_d = entry_q;
		ang     = '0;
		lin     = '0;
		lost    = 1'b0;

		if (item.command == CMD_START) begin
			mode_d = M_START;
		end else if (pose == P_MISSING) begin
			lost = 1'b1;
		end else begin
			unique case (mode_q)
				M_START: begin
					if (pose == P_IN_NORMAL || pose == P_IN_LHRL || pose == P_IN_LLRH ||
					    pose == P_OUT_NORMAL) begin
						entry_d = sl;
						mode_d  = M_GOTOLINE;
					end else if (pose == P_OUT_LHRL || pose == P_OUT_LLRH) begin
						mode_d = M_FINDDIR;
					end else if (pose == P_ALIGNED) begin
						mode_d = M_TRACE;
					end else begin
						entry_d = SIDE_INSIDE[0];
						mode_d  = M_ALIGNING;
					end
				end
				M_FINDDIR: begin
					if (pose == P_OUT_LHRL) begin
						ang = tgt_s;
					end else if (pose == P_OUT_LLRH) begin
						ang = -tgt_s;
					end else begin
						mode_d = M_START;
					end
				end
				M_GOTOLINE: begin
					if (entry_q != sl || entry_q != sr) begin
						mode_d = (pose == P_ALIGNED) ? M_TRACE : M_ALIGNING;
					end else begin
						if (item.left_level > item.right_level) begin
							ang = f64_s;
						end else if (item.left_level < item.right_level) begin
							ang = -f64_s;
						end
						lin = target_speed;
					end
				end
				M_ALIGNING: begin
					if (pose == P_ALIGNED) begin
						mode_d = M_TRACE;
					end else begin
						ang = pos_dir ? tgt_s : -tgt_s;
						lin = frac64;
					end
				end
				M_TRACE: begin
					if (sl == sr) begin
						ang = pos_dir ? f192_s : -f192_s;
					end else begin
						ang = (item.left_level > item.right_level) ? f26_s : -f26_s;
					end
					lin = target_speed;
				end
				M_DONE: begin
					mode_d = M_IDLE;
				end
				default: begin
				end
			endcase
		end

		result.turn_rate     = ang;
		result.forward_speed = lin;
		result.wire_lost     = lost;
		result.mode_now      = mode_d;
		result.pose_class    = pose;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			entry_q <= SIDE_INSIDE[0];
		end else if (step) begin
			mode_q  <= mode_d;
			entry_q <= entry_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_lost_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.wire_lost |-> result.turn_rate == '0 && result.forward_speed == '0)
		else $error("wire lost with nonzero velocity");

	a_start_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command == CMD_START |=> mode_q == M_START)
		else $error("start command did not enter start");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(entry_q))
		else $error("mode changed without a transaction");

	a_drive_modes: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.forward_speed != '0 |->
		mode_q == M_GOTOLINE || mode_q == M_ALIGNING || mode_q == M_TRACE)
		else $error("forward speed outside a driving mode");
`endif

endmodule

// ===== rtl/boundary_wire_follow_fsm.sv =====
// Boundary-wire follower for a two-coil robot.
// Input channel (in_valid / in_stall / in_item): one transaction per sensor
// sample or start command. Output channel (out_valid / out_stall / out_item):
// exactly one result per input transaction, in order: turn rate, forward
// speed, wire-lost flag, mode after the step and orientation class.
// Config port (cfg_we / cfg_index / cfg_data): 0 target speed, 1 wire
// reversed, 2 facing margin; write only while no transaction is in flight.
// Each transaction passes through the input register, then the classify and
// mode update into the result register.
// Throughput: one transaction per cycle while out_stall is low; the
// combinational classify/mode update between the two registers sets it.
// When out_stall is high the result holds and one more transaction can sit
// in the input register; after that in_stall rises.
// Reset: mode idle, entry side inside, target speed 0, direct wire, facing
// margin 26; both registers empty.
module boundary_wire_follow_fsm
	import bwf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_item,
	input  logic               cfg_we,
	input  cfg_index_t         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	logic [SPEED_W-1:0] target_speed_q;
	logic               wire_reversed_q;
	logic [7:0]         facing_margin_q;

	logic  valid_s1;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_item_q;
	logic  s2_ready;
	logic  advance;
	pose_t pose;
	out_t  result;

	assign s2_ready  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !s2_ready;
	assign advance   = valid_s1 && s2_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q  <= '0;
			wire_reversed_q <= 1'b0;
			facing_margin_q <= FACING_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_SPEED:  target_speed_q  <= cfg_data[SPEED_W-1:0];
				CFG_WIRE_REVERSED: wire_reversed_q <= cfg_data[0];
				CFG_FACING_MARGIN: facing_margin_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				out_valid_q <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_item_q <= result;
		end
	end

	bwf_classify u_classify (
		.item          (item_s1),
		.facing_margin (facing_margin_q),
		.wire_reversed (wire_reversed_q),
		.pose          (pose)
	);

	bwf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.pose          (pose),
		.target_speed  (target_speed_q),
		.wire_reversed (wire_reversed_q),
		.result        (result)
	);

endmodule

// ===== dv/boundary_wire_follow_fsm_test.sv =====
`timescale 1ns / 100ps

import bwf_pkg::*;

typedef enum logic [2:0] {
	MODE_IDLE     = 3'd0,
	MODE_START    = 3'd1,
	MODE_FINDDIR  = 3'd2,
	MODE_GOTOLINE = 3'd3,
	MODE_ALIGNING = 3'd4,
	MODE_TRACE    = 3'd5,
	MODE_DONE     = 3'd6
} mode_t;

localparam logic [1:0] SIDE_MISSING = 2'd2;
localparam logic [1:0] SIDE_UNUSED  = 2'd3;

class motion_scoreboard;
	logic [SPEED_W-1:0] target_speed  = '0;
	logic               wire_reversed = 1'b0;
	logic [7:0]         facing_margin = FACING_MARGIN_RST;
	mode_t              mode          = MODE_IDLE;
	logic [1:0]         entry_side    = SIDE_INSIDE;
	out_t               awaited[$];
	int unsigned        errors        = 0;

	function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_TARGET_SPEED:  target_speed = data[SPEED_W-1:0];
			CFG_WIRE_REVERSED: wire_reversed = data[0];
			CFG_FACING_MARGIN: facing_margin = data[7:0];
			default: ;
		endcase
	endfunction

	function pose_t orient(logic [1:0] sl, logic [1:0] sr,
			logic signed [LEVEL_W-1:0] vl, logic signed [LEVEL_W-1:0] vr);
		int unsigned a, b, k;
		pose_t base;
		if (sl > SIDE_OUTSIDE || sr > SIDE_OUTSIDE)
			return P_MISSING;
		if (sl == sr) begin
			a = (vl < 0) ? -int'(vl) : int'(vl);
			b = (vr < 0) ? -int'(vr) : int'(vr);
			k = 256 + facing_margin;
			base = (sl == SIDE_INSIDE) ? P_IN_NORMAL : P_OUT_NORMAL;
			if (a * 256 < b * k && b * 256 < a * k)
				return base;
			return (a > b) ? pose_t'(base + 1) : pose_t'(base + 2);
		end
		if (!wire_reversed)
			return (sl == SIDE_INSIDE) ? P_ALIGNED : P_REVERSE;
		return (sl == SIDE_INSIDE) ? P_REVERSE : P_ALIGNED;
	endfunction

	// fraction num/256 of the target speed, truncated
	function int scaled(int unsigned num);
		int unsigned prod;
		prod = target_speed * num;
		return int'(prod >> 8);
	endfunction

	function void note_sample(in_t item);
		int ang, lin, tgt;
		logic lost;
		logic ccw;
		pose_t pose;
		logic [1:0] sl, sr;
		logic signed [LEVEL_W-1:0] vl, vr;
		out_t res;
		sl = item.left_side;
		sr = item.right_side;
		vl = item.left_level;
		vr = item.right_level;
		ang = 0;
		lin = 0;
		lost = 1'b0;
		tgt = int'(target_speed);
		pose = orient(sl, sr, vl, vr);
		if (item.command == CMD_START) begin
			mode = MODE_START;
		end else if (pose == P_MISSING) begin
			lost = 1'b1;
		end else begin
			case (mode)
				MODE_START: begin
					if (pose inside {P_IN_NORMAL, P_IN_LHRL, P_IN_LLRH, P_OUT_NORMAL}) begin
						entry_side = sl;
						mode = MODE_GOTOLINE;
					end else if (pose inside {P_OUT_LHRL, P_OUT_LLRH}) begin
						mode = MODE_FINDDIR;
					end else if (pose == P_ALIGNED) begin
						mode = MODE_TRACE;
					end else begin
						entry_side = SIDE_INSIDE;
						mode = MODE_ALIGNING;
					end
				end
				MODE_FINDDIR: begin
					if (pose == P_OUT_LHRL)
						ang = tgt;
					else if (pose == P_OUT_LLRH)
						ang = -tgt;
					else
						mode = MODE_START;
				end
				MODE_GOTOLINE: begin
					if (entry_side != sl || entry_side != sr) begin
						mode = (pose == P_ALIGNED) ? MODE_TRACE : MODE_ALIGNING;
					end else begin
						if (vl > vr)
							ang = scaled(64);
						else if (vl < vr)
							ang = -scaled(64);
						lin = tgt;
					end
				end
				MODE_ALIGNING: begin
					if (pose == P_ALIGNED) begin
						mode = MODE_TRACE;
					end else begin
						ccw = wire_reversed ? (sl == SIDE_INSIDE) : (sl == SIDE_OUTSIDE);
						ang = ccw ? tgt : -tgt;
						lin = scaled(64);
					end
				end
				MODE_TRACE: begin
					if (sl == sr) begin
						ccw = wire_reversed ? (sl == SIDE_INSIDE) : (sl == SIDE_OUTSIDE);
						ang = ccw ? scaled(192) : -scaled(192);
					end else begin
						ang = (vl > vr) ? scaled(26) : -scaled(26);
					end
					lin = tgt;
				end
				MODE_DONE: mode = MODE_IDLE;
				default: ;
			endcase
		end
		res.turn_rate = ang[TURN_W-1:0];
		res.forward_speed = lin[SPEED_W-1:0];
		res.wire_lost = lost;
		res.mode_now = mode;
		res.pose_class = pose;
		awaited.push_back(res);
	endfunction

	function void check_motion(out_t got);
		out_t want;
		if (awaited.size() == 0) begin
			$error("unexpected transaction on output: %h", got);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (got.turn_rate !== want.turn_rate) begin
			$error("turn_rate: expected %0d, got %0d", want.turn_rate, got.turn_rate);
			errors++;
		end
		if (got.forward_speed !== want.forward_speed) begin
			$error("forward_speed: expected %0d, got %0d", want.forward_speed,
				got.forward_speed);
			errors++;
		end
		if (got.wire_lost !== want.wire_lost) begin
			$error("wire_lost: expected %0d, got %0d", want.wire_lost, got.wire_lost);
			errors++;
		end
		if (got.mode_now !== want.mode_now) begin
			$error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
			errors++;
		end
		if (got.pose_class !== want.pose_class) begin
			$error("pose_class: expected %0d, got %0d", want.pose_class, got.pose_class);
			errors++;
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module boundary_wire_follow_fsm_test;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 60;
	localparam int PHASE_ITEMS = 100;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_t              in_item;
	logic             out_valid;
	logic             out_stall;
	out_t             out_item;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	motion_scoreboard sb = new;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit long_hold_req = 1'b0;
	int sent_items = 0;
	int quiet_cycles = 0;

	boundary_wire_follow_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(in_item);
			if (out_valid && !out_stall)
				sb.check_motion(out_item);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("boundary_wire_follow_fsm verification failed");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0)
				hold_left--;
			else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end else if (rx_idle && $urandom_range(0, 5) == 0)
				hold_left = $urandom_range(1, 8);
			out_stall <= (hold_left > 0);
		end
	end

	function automatic int rand_level();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	function automatic in_t fixed_item(logic cmd, logic [1:0] sl, logic [1:0] sr,
			int vl, int vr);
		in_t item;
		item.command = cmd;
		item.left_side = sl;
		item.right_side = sr;
		item.left_level = vl[LEVEL_W-1:0];
		item.right_level = vr[LEVEL_W-1:0];
		return item;
	endfunction

	// levels are often close to each other so the margin test is hit on both sides
	function automatic in_t sample_item(logic cmd, logic [1:0] sl, logic [1:0] sr);
		int a, b, d;
		a = rand_level();
		if ($urandom_range(0, 4) < 2) begin
			b = rand_level();
		end else begin
			d = $urandom_range(0, 120);
			b = ((a < 0 ? -a : a) * (196 + d)) / 256;
			if (b > 32767)
				b = 32767;
			if ($urandom_range(0, 1))
				b = -b;
		end
		if ($urandom_range(0, 1))
			return fixed_item(cmd, sl, sr, a, b);
		return fixed_item(cmd, sl, sr, b, a);
	endfunction

	task automatic send_item(input in_t item);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic program_regs(input logic [15:0] speed, input logic rev,
			input logic [7:0] margin);
		drain();
		write_reg(CFG_TARGET_SPEED, speed);
		write_reg(CFG_WIRE_REVERSED, {15'd0, rev});
		write_reg(CFG_FACING_MARGIN, {8'd0, margin});
		write_reg(CFG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// start command, then a run of samples that walks the mode machine
	task automatic run_sequence();
		logic [1:0] sl, sr;
		int n;
		n = $urandom_range(3, 14);
		send_item(sample_item(CMD_START, 2'($urandom_range(0, 1)),
			2'($urandom_range(0, 1))));
		repeat (n) begin
			sl = 2'($urandom_range(0, 1));
			sr = ($urandom_range(0, 2) == 0) ? (sl ^ 2'd1) : sl;
			if ($urandom_range(0, 19) == 0)
				sr = 2'($urandom_range(2, 3));
			if ($urandom_range(0, 19) == 0)
				sl = 2'($urandom_range(2, 3));
			send_item(sample_item(1'b0, sl, sr));
		end
	endtask

	task automatic random_phase();
		int stop_at;
		stop_at = sent_items + PHASE_ITEMS;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 99) < 85)
				run_sequence();
			else
				send_item(sample_item($urandom_range(0, 7) == 0, 2'($urandom), 2'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET_SPEED;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(16'd1234, 1'b0, FACING_MARGIN_RST);
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 100, 100));
		send_item(fixed_item(1'b0, SIDE_UNUSED, SIDE_INSIDE, 0, 0));
		send_item(fixed_item(CMD_START, SIDE_MISSING, SIDE_OUTSIDE, -32768, 32767));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 32767, -32768));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 32767, -32768));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, -5, 5));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 7, 7));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_MISSING, 0, 0));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_INSIDE, 10, 20));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 1000, 100));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 100, 1000));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_OUTSIDE, 0, 0));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 0, 0));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 3, 3));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_OUTSIDE, 200, -300));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_INSIDE, -300, 200));
		send_item(fixed_item(CMD_START, SIDE_OUTSIDE, SIDE_OUTSIDE, 0, 0));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 5000, 100));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 5000, 100));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, -100, 5000));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 1000, 1050));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_OUTSIDE, 1000, -1050));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_INSIDE, 10, 10));
		send_item(fixed_item(CMD_START, SIDE_INSIDE, SIDE_INSIDE, 0, 0));
		send_item(fixed_item(1'b0, SIDE_INSIDE, SIDE_OUTSIDE, 40, 40));
		send_item(fixed_item(CMD_START, SIDE_INSIDE, SIDE_INSIDE, 0, 0));
		send_item(fixed_item(1'b0, SIDE_OUTSIDE, SIDE_INSIDE, 40, 40));

		program_regs(16'hFFFF, 1'b1, 8'd255);
		random_phase();

		program_regs(16'd0, 1'b0, 8'd0);
		random_phase();

		// sender never idles while the receiver holds off, so the block backs up
		program_regs(16'($urandom), 1'($urandom), 8'($urandom));
		tx_idle = 1'b0;
		long_hold_req = 1'b1;
		random_phase();
		tx_idle = 1'b1;

		program_regs(16'hFFFF, 1'b0, 8'd0);
		random_phase();

		program_regs(16'($urandom), 1'b1, FACING_MARGIN_RST);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		random_phase();

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("boundary_wire_follow_fsm verification clean");
		else
			$display("boundary_wire_follow_fsm verification failed");
		$finish;
	end

endmodule
